/* rtl/ppba_pkg.sv */
// ----------------------------------------------------------------------------
// ppba_pkg
// Shared constants and types for the two-zone bitmap page allocator.
// ----------------------------------------------------------------------------
package ppba_pkg;

   localparam int PAGES_PER_ZONE = 128;
   localparam int ZONE_COUNT     = 2;

   localparam int PAGE_AW   = $clog2(PAGES_PER_ZONE);
   localparam int MAP_DEPTH = ZONE_COUNT * PAGES_PER_ZONE;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int ZONE_AW   = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

   // fixed field widths
   localparam int CNT_W  = 8;
   localparam int PAGE_W = 7;
   localparam int CSR_AW = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_AW-1:0] CSR_ZONE0_POOL   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_ZONE1_POOL   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_CONTIG_LIMIT = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // one bit write into the page map
   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] idx;
      logic              used;
   } map_wr_type;

endpackage

/* rtl/ppba_map.sv */
// ----------------------------------------------------------------------------
// ppba_map
// Page usage map: one flag per page of every zone, held in a memory.
// One registered read and one single-bit write per cycle. After reset a
// clearing pass marks every page free, one entry a cycle, and busy
// stays high until it is done.
// ----------------------------------------------------------------------------
module ppba_map
   import ppba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [MAP_AW-1:0] rd_idx,
   output logic              rd_used,
   input  map_wr_type        wr,
   output logic              busy
);

   logic              used_mem [MAP_DEPTH];
   logic              rd_used_ff;
   logic              clr_busy_ff;
   logic [MAP_AW-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + MAP_AW'(1);
         if (clr_idx_ff == MAP_AW'(MAP_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         used_mem[clr_idx_ff] <= 1'b0;
      end else if (wr.en) begin
         used_mem[wr.idx] <= wr.used;
      end
      rd_used_ff <= used_mem[rd_idx];
   end

   assign rd_used = rd_used_ff;
   assign busy    = clr_busy_ff;

endmodule

/* rtl/page_pool_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_pool_bitmap_allocator_top
// Two-zone first-fit page allocator. A sequencer walks the page map one flag
// per cycle through a single registered read port, whose address is issued a
// cycle ahead, and one compare unit.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; req_stall is high until the sequencer
//   hands its result to the output register, which decouples rsp_stall.
// Reset: synchronous; counters go to 128 at once, then a clearing pass marks
//   every page free while req_stall stays high.
// ----------------------------------------------------------------------------
module page_pool_bitmap_allocator_top
   import ppba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic              req_zone,
   input  logic [CNT_W-1:0]  req_page_count,
   input  logic [PAGE_W-1:0] req_start_page,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_status,
   output logic [PAGE_W-1:0] rsp_page_index,
   output logic [CNT_W-1:0]  rsp_zone_free_count,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CNT_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_UP,
      ST_SCAN_DN,
      ST_CHECK,
      ST_MARK,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_pages(input logic [CNT_W-1:0] v);
      return (int'(v) > PAGES_PER_ZONE) ? CNT_W'(PAGES_PER_ZONE) : v;
   endfunction

   function automatic logic [MAP_AW-1:0] map_index(input logic [ZONE_AW-1:0] z,
                                                   input logic [PAGE_AW-1:0] p);
      return MAP_AW'(int'(z) * PAGES_PER_ZONE + int'(p));
   endfunction

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    pool0_ff, pool0_in;
   logic [CNT_W-1:0]    pool1_ff, pool1_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    free_count_ff [ZONE_COUNT];
   logic [CNT_W-1:0]    free_count_in [ZONE_COUNT];

   logic                mode_ff, mode_in;
   logic [ZONE_AW-1:0]  zone_ff, zone_in;
   logic                zone_ok_ff, zone_ok_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    end_ff, end_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic                status_ff, status_in;
   logic [CNT_W-1:0]    index_ff, index_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_index_ff, rsp_page_index_in;
   logic [CNT_W-1:0]    rsp_fc_ff, rsp_fc_in;

   logic [CNT_W-1:0]    rd_page;
   logic [MAP_AW-1:0]   rd_idx;
   logic [CNT_W-1:0]    rd_page_nxt;
   logic [MAP_AW-1:0]   rd_idx_nxt;
   logic                rd_used;
   logic                map_busy;
   map_wr_type          map_wr;

   logic                req_xfer;
   logic                req_zone_ok;
   logic [ZONE_AW-1:0]  req_zid;
   logic [CNT_W-1:0]    req_pool;
   logic [CNT_W-1:0]    req_fc;
   logic [CNT_W:0]      req_end;
   logic [CNT_W-1:0]    cur_fc;
   logic [CNT_W:0]      fc_sum;

   ppba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx_nxt),
      .rd_used (rd_used),
      .wr      (map_wr),
      .busy    (map_busy)
   );

   assign req_stall = reset || map_busy || (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign req_zone_ok = int'(req_zone) < ZONE_COUNT;
   assign req_zid     = ZONE_AW'(req_zone);
   assign req_pool    = clamp_pages(req_zone ? pool1_ff : pool0_ff);
   assign req_fc      = req_zone_ok ? free_count_ff[req_zid] : '0;
   assign req_end     = {1'b0, CNT_W'(req_start_page)} + {1'b0, req_page_count};

   assign cur_fc = free_count_ff[zone_ff];
   assign fc_sum = {1'b0, cur_fc} + {1'b0, count_ff};

   // downward scan looks at the page just below the cursor
   assign rd_page = (state_ff == ST_SCAN_DN) ? (ptr_ff - CNT_W'(1)) : ptr_ff;
   assign rd_idx  = map_index(zone_ff, rd_page[PAGE_AW-1:0]);

   // map read is registered: fetch the flag the next state will look at
   assign rd_page_nxt = (state_in == ST_SCAN_DN) ? (ptr_in - CNT_W'(1)) : ptr_in;
   assign rd_idx_nxt  = map_index(zone_in, rd_page_nxt[PAGE_AW-1:0]);

   always_comb begin
      state_in          = state_ff;
      pool0_in          = pool0_ff;
      pool1_in          = pool1_ff;
      limit_in          = limit_ff;
      free_count_in     = free_count_ff;
      mode_in           = mode_ff;
      zone_in           = zone_ff;
      zone_ok_in        = zone_ok_ff;
      count_in          = count_ff;
      start_in          = start_ff;
      ptr_in            = ptr_ff;
      end_in            = end_ff;
      run_in            = run_ff;
      status_in         = status_ff;
      index_in          = index_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_page_index_in = rsp_page_index_ff;
      rsp_fc_in         = rsp_fc_ff;
      map_wr            = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ZONE0_POOL:   pool0_in = csr_wdata;
            CSR_ZONE1_POOL:   pool1_in = csr_wdata;
            CSR_CONTIG_LIMIT: limit_in = csr_wdata;
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in    = req_mode;
               zone_in    = req_zid;
               zone_ok_in = req_zone_ok;
               count_in   = req_page_count;
               start_in   = CNT_W'(req_start_page);
               status_in  = 1'b1;
               index_in   = '0;
               run_in     = '0;
               state_in   = ST_DONE;
               if (req_zone_ok) begin
                  if (req_mode == MODE_ALLOC) begin
                     if (req_page_count != '0 && req_page_count <= req_fc) begin
                        if (req_page_count == CNT_W'(1)) begin
                           ptr_in   = '0;
                           end_in   = req_pool;
                           state_in = ST_SCAN_UP;
                        end else begin
                           ptr_in   = clamp_pages(limit_ff);
                           state_in = ST_SCAN_DN;
                        end
                     end
                  end else if (CNT_W'(req_start_page) < req_pool &&
                               req_end <= {1'b0, req_pool}) begin
                     ptr_in   = CNT_W'(req_start_page);
                     end_in   = req_end[CNT_W-1:0];
                     state_in = ST_CHECK;
                  end
               end
            end
         end

         ST_SCAN_UP: begin
            if (ptr_ff >= end_ff) begin
               state_in = ST_DONE;
            end else if (!rd_used) begin
               index_in  = ptr_ff;
               end_in    = ptr_ff + CNT_W'(1);
               status_in = 1'b0;
               state_in  = ST_MARK;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end

         ST_SCAN_DN: begin
            if (ptr_ff == '0) begin
               state_in = ST_DONE;
            end else if (!rd_used) begin
               if (run_ff + CNT_W'(1) == count_ff) begin
                  index_in  = rd_page;
                  ptr_in    = rd_page;
                  end_in    = rd_page + count_ff;
                  status_in = 1'b0;
                  state_in  = ST_MARK;
               end else begin
                  run_in = run_ff + CNT_W'(1);
                  ptr_in = rd_page;
               end
            end else begin
               run_in = '0;
               ptr_in = rd_page;
            end
         end

         ST_CHECK: begin
            if (ptr_ff == end_ff) begin
               ptr_in    = start_ff;
               status_in = 1'b0;
               state_in  = ST_MARK;
            end else if (!rd_used) begin
               // page already free: reject, map untouched
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end

         ST_MARK: begin
            if (ptr_ff == end_ff) begin
               if (mode_ff == MODE_ALLOC) begin
                  free_count_in[zone_ff] = cur_fc - count_ff;
               end else begin
                  free_count_in[zone_ff] = fc_sum[CNT_W] ? CNT_MAX : fc_sum[CNT_W-1:0];
               end
               state_in = ST_DONE;
            end else begin
               map_wr.en   = 1'b1;
               map_wr.idx  = rd_idx;
               map_wr.used = (mode_ff == MODE_ALLOC);
               ptr_in      = ptr_ff + CNT_W'(1);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_page_index_in = status_ff ? '0 : index_ff[PAGE_W-1:0];
               rsp_fc_in         = zone_ok_ff ? cur_fc : '0;
               state_in          = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         pool0_ff          <= CNT_W'(128);
         pool1_ff          <= CNT_W'(128);
         limit_ff          <= CNT_W'(128);
         for (int i = 0; i < ZONE_COUNT; i++) begin
            free_count_ff[i] <= CNT_W'(PAGES_PER_ZONE);
         end
         mode_ff           <= MODE_ALLOC;
         zone_ff           <= '0;
         zone_ok_ff        <= 1'b0;
         count_ff          <= '0;
         start_ff          <= '0;
         ptr_ff            <= '0;
         end_ff            <= '0;
         run_ff            <= '0;
         status_ff         <= 1'b1;
         index_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_status_ff     <= 1'b0;
         rsp_page_index_ff <= '0;
         rsp_fc_ff         <= '0;
      end else begin
         state_ff          <= state_in;
         pool0_ff          <= pool0_in;
         pool1_ff          <= pool1_in;
         limit_ff          <= limit_in;
         free_count_ff     <= free_count_in;
         mode_ff           <= mode_in;
         zone_ff           <= zone_in;
         zone_ok_ff        <= zone_ok_in;
         count_ff          <= count_in;
         start_ff          <= start_in;
         ptr_ff            <= ptr_in;
         end_ff            <= end_in;
         run_ff            <= run_in;
         status_ff         <= status_in;
         index_ff          <= index_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_page_index_ff <= rsp_page_index_in;
         rsp_fc_ff         <= rsp_fc_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_page_index      = rsp_page_index_ff;
   assign rsp_zone_free_count = rsp_fc_ff;

   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (ptr_ff <= end_ff))
      else $error("mark cursor ran past range end");

   a_map_write_in_mark: assert property (@(posedge clock) disable iff (reset)
      map_wr.en |-> (state_ff == ST_MARK))
      else $error("page map written outside mark phase");

   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_page_index_ff == '0))
      else $error("failed response carries a page index");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done state");

endmodule
